// ===== hdl/stcd_pkg.sv =====
package stcd_pkg;

    localparam int TIME_W   = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam int NSTG = 10;

    // gps epoch 1980-01-06 in unix seconds
    localparam logic [TIME_W:0] GPS_OFFSET = 33'd315964800;

    // days = (t >> 7) / 675, exact reciprocal for a 26-bit dividend
    localparam logic [26:0] M_DAY = 27'd101806633;
    localparam int          S_DAY = 36;
    localparam logic [25:0] SEC_PER_DAY_HI = 26'd675;

    // day count of 2000-03-01, start of the 400-year era that begins in 2000
    localparam logic [15:0] ERA5_FIRST_DAY = 16'd11017;
    localparam logic [17:0] ERA4_DOE_BASE  = 18'd135080;

    localparam logic [18:0] M_1460 = 19'd367720;
    localparam int          S_1460 = 29;
    localparam logic [17:0] M_3600 = 18'd149131;
    localparam int          S_3600 = 29;
    localparam logic [12:0] M_60   = 13'd4370;
    localparam int          S_60   = 18;
    localparam logic [18:0] M_365  = 19'd367720;
    localparam int          S_365  = 27;
    localparam logic [11:0] M_153  = 12'd3427;
    localparam int          S_153  = 19;

    localparam logic [17:0] DAYS_CENT1 = 18'd36524;
    localparam logic [17:0] DAYS_CENT2 = 18'd73048;
    localparam logic [17:0] DAYS_CENT3 = 18'd109572;
    localparam logic [17:0] DAYS_CENT4 = 18'd146096;

    // day of march-based year on which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/stcd_if.sv =====
interface stcd_in_if import stcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_value;
    logic              epoch_select;

    modport source (output valid, output time_value, output epoch_select, input ready);
    modport sink   (input valid, input time_value, input epoch_select, output ready);
endinterface

interface stcd_out_if import stcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output second_out, input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input second_out, output ready);
endinterface

// ===== hdl/seconds_to_calendar_date_top.sv =====
// a 10-stage pipeline takes one item per cycle unless the output stalls
// each stage holds at most one reciprocal multiply
// a stalled output holds its stage, earlier stages keep filling any empty slots
// reset: synchronous active-low i_rst_n clears all stage valid bits, no items pending
module seconds_to_calendar_date_top import stcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stcd_in_if.sink     i_in,
    stcd_out_if.source  o_out
);

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: unix seconds
    logic [TIME_W:0] r_s1_t;
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_t <= {1'b0, i_in.time_value} + (i_in.epoch_select ? '0 : GPS_OFFSET);
        end
    end

    // stage 2: day count by reciprocal of 675 on t >> 7
    logic [52:0]     w_prod_day;
    logic [15:0]     r_s2_q;
    logic [TIME_W:0] r_s2_t;
    assign w_prod_day = 53'(r_s1_t[TIME_W:7]) * 53'(M_DAY);
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_q <= w_prod_day[S_DAY+15:S_DAY];
            r_s2_t <= r_s1_t;
        end
    end

    // stage 3: seconds of day
    logic [25:0] w_rem_hi;
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_rem;
    assign w_rem_hi = r_s2_t[TIME_W:7] - 26'(26'(r_s2_q) * SEC_PER_DAY_HI);
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_days <= r_s2_q;
            r_s3_rem  <= {w_rem_hi[9:0], r_s2_t[6:0]};
        end
    end

    // stage 4: day of era, hour
    logic              w_era5;
    logic [34:0]       w_prod_hour;
    logic [17:0]       r_s4_doe;
    logic              r_s4_era5;
    logic [16:0]       r_s4_rem;
    logic [HOUR_W-1:0] r_s4_hour;
    assign w_era5      = r_s3_days >= ERA5_FIRST_DAY;
    assign w_prod_hour = 35'(r_s3_rem) * 35'(M_3600);
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_doe  <= w_era5 ? 18'(r_s3_days) - 18'(ERA5_FIRST_DAY)
                                : 18'(r_s3_days) + ERA4_DOE_BASE;
            r_s4_era5 <= w_era5;
            r_s4_rem  <= r_s3_rem;
            r_s4_hour <= w_prod_hour[S_3600+HOUR_W-1:S_3600];
        end
    end

    // stage 5: leap corrections of the year-of-era formula, seconds of hour
    logic [36:0]       w_prod_a;
    logic [17:0]       r_s5_doe;
    logic [6:0]        r_s5_a;
    logic [2:0]        r_s5_b;
    logic              r_s5_c;
    logic              r_s5_era5;
    logic [HOUR_W-1:0] r_s5_hour;
    logic [11:0]       r_s5_rem2;
    assign w_prod_a = 37'(r_s4_doe) * 37'(M_1460);
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_doe  <= r_s4_doe;
            r_s5_a    <= w_prod_a[S_1460+6:S_1460];
            r_s5_b    <= 3'(r_s4_doe >= DAYS_CENT1) + 3'(r_s4_doe >= DAYS_CENT2)
                       + 3'(r_s4_doe >= DAYS_CENT3) + 3'(r_s4_doe >= DAYS_CENT4);
            r_s5_c    <= r_s4_doe >= DAYS_CENT4;
            r_s5_era5 <= r_s4_era5;
            r_s5_hour <= r_s4_hour;
            r_s5_rem2 <= 12'(r_s4_rem - 17'(17'(r_s4_hour) * 17'd3600));
        end
    end

    // stage 6: year-of-era numerator, minute
    logic [24:0]         w_prod_min;
    logic [17:0]         r_s6_num;
    logic [17:0]         r_s6_doe;
    logic                r_s6_era5;
    logic [HOUR_W-1:0]   r_s6_hour;
    logic [11:0]         r_s6_rem2;
    logic [MINUTE_W-1:0] r_s6_minute;
    assign w_prod_min = 25'(r_s5_rem2) * 25'(M_60);
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_num    <= r_s5_doe - 18'(r_s5_a) + 18'(r_s5_b) - 18'(r_s5_c);
            r_s6_doe    <= r_s5_doe;
            r_s6_era5   <= r_s5_era5;
            r_s6_hour   <= r_s5_hour;
            r_s6_rem2   <= r_s5_rem2;
            r_s6_minute <= w_prod_min[S_60+MINUTE_W-1:S_60];
        end
    end

    // stage 7: year of era, second
    logic [36:0]         w_prod_yoe;
    logic [8:0]          r_s7_yoe;
    logic [17:0]         r_s7_doe;
    logic                r_s7_era5;
    logic [HOUR_W-1:0]   r_s7_hour;
    logic [MINUTE_W-1:0] r_s7_minute;
    logic [SECOND_W-1:0] r_s7_second;
    assign w_prod_yoe = 37'(r_s6_num) * 37'(M_365);
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_yoe    <= w_prod_yoe[S_365+8:S_365];
            r_s7_doe    <= r_s6_doe;
            r_s7_era5   <= r_s6_era5;
            r_s7_hour   <= r_s6_hour;
            r_s7_minute <= r_s6_minute;
            r_s7_second <= 6'(r_s6_rem2 - 12'(12'(r_s6_minute) * 12'd60));
        end
    end

    // stage 8: day of march-based year
    logic [1:0]          w_cent;
    logic [17:0]         w_doy;
    logic [8:0]          r_s8_doy;
    logic [8:0]          r_s8_yoe;
    logic                r_s8_era5;
    logic [HOUR_W-1:0]   r_s8_hour;
    logic [MINUTE_W-1:0] r_s8_minute;
    logic [SECOND_W-1:0] r_s8_second;
    assign w_cent = 2'(r_s7_yoe >= 9'd100) + 2'(r_s7_yoe >= 9'd200)
                  + 2'(r_s7_yoe >= 9'd300);
    assign w_doy  = r_s7_doe - (18'(r_s7_yoe) * 18'd365 + 18'(r_s7_yoe[8:2]) - 18'(w_cent));
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_doy    <= w_doy[8:0];
            r_s8_yoe    <= r_s7_yoe;
            r_s8_era5   <= r_s7_era5;
            r_s8_hour   <= r_s7_hour;
            r_s8_minute <= r_s7_minute;
            r_s8_second <= r_s7_second;
        end
    end

    // stage 9: month index counted from march
    logic [10:0]         w_mp_num;
    logic [22:0]         w_prod_mp;
    logic [3:0]          r_s9_mp;
    logic [8:0]          r_s9_doy;
    logic [8:0]          r_s9_yoe;
    logic                r_s9_era5;
    logic [HOUR_W-1:0]   r_s9_hour;
    logic [MINUTE_W-1:0] r_s9_minute;
    logic [SECOND_W-1:0] r_s9_second;
    assign w_mp_num  = 11'(r_s8_doy) * 11'd5 + 11'd2;
    assign w_prod_mp = 23'(w_mp_num) * 23'(M_153);
    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s9_mp     <= w_prod_mp[S_153+3:S_153];
            r_s9_doy    <= r_s8_doy;
            r_s9_yoe    <= r_s8_yoe;
            r_s9_era5   <= r_s8_era5;
            r_s9_hour   <= r_s8_hour;
            r_s9_minute <= r_s8_minute;
            r_s9_second <= r_s8_second;
        end
    end

    // stage 10: calendar fields; january and february belong to the next year
    logic                w_jan_feb;
    logic [8:0]          w_day;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic [SECOND_W-1:0] r_second;
    assign w_jan_feb = r_s9_mp >= 4'd10;
    assign w_day     = r_s9_doy - month_start(r_s9_mp) + 9'd1;
    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_year   <= 12'(r_s9_yoe) + (r_s9_era5 ? 12'd2000 : 12'd1600) + 12'(w_jan_feb);
            r_month  <= w_jan_feb ? r_s9_mp - 4'd9 : r_s9_mp + 4'd3;
            r_day    <= w_day[DAY_W-1:0];
            r_hour   <= r_s9_hour;
            r_minute <= r_s9_minute;
            r_second <= r_s9_second;
        end
    end

    assign o_out.valid      = r_v[NSTG-1];
    assign o_out.year_out   = r_year;
    assign o_out.month_out  = r_month;
    assign o_out.day_out    = r_day;
    assign o_out.hour_out   = r_hour;
    assign o_out.minute_out = r_minute;
    assign o_out.second_out = r_second;

endmodule
